// File: sv/pose_delta_body_velocity_unit_assert.svh
// Assertion macros used by the pose delta velocity checker.
`ifndef POSE_DELTA_BODY_VELOCITY_UNIT_ASSERT_SVH
`define POSE_DELTA_BODY_VELOCITY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PDBV_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pdbv assertion failed");

// Next-cycle implication, disabled during reset.
`define PDBV_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pdbv assertion failed");

`endif

// File: sv/pdbv_pkg.sv
// Types, constants and helper functions of the pose delta velocity block.
`timescale 1ns / 1ps
package pdbv_pkg;

   localparam int PosWidth    = 32;
   localparam int QuatWidth   = 16;
   localparam int StampWidth  = 32;
   localparam int VelWidth    = 32;
   localparam int YawWidth    = 16;
   localparam int ProdWidth   = 2 * QuatWidth;
   localparam int SumWidth    = ProdWidth + 3;
   localparam int CordWidth   = 36;
   localparam int AngWidth    = 34;
   localparam int StepWidth   = 5;
   localparam int TableLen    = 24;
   localparam int DivWidth    = 43;
   localparam int ScWidth     = 22;
   localparam int MacAWidth   = 23;
   localparam int MacPWidth   = MacAWidth + ScWidth;
   localparam int AccWidth    = 66;
   localparam int MacCntWidth = 3;
   localparam int SatInWidth  = 48;

   localparam logic signed [YawWidth:0]    PiQ13         = 17'sd25736;
   localparam logic signed [YawWidth:0]    TwoPiQ13      = 17'sd51472;
   localparam logic signed [AngWidth-1:0]  PiQ30         = 34'sd3373259426;
   localparam logic signed [AngWidth-1:0]  HalfPiQ30     = 34'sd1686629713;
   localparam logic signed [CordWidth-1:0] CordicGainQ30 = 36'sd652032874;

   typedef struct packed {
      logic load_in;
      logic prod_sq;
      logic prod_cross;
      logic setup_vec;
      logic cordic_step;
      logic cordic_vec;
      logic take_yaw;
      logic setup_rot;
      logic take_sc;
      logic mac_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic hold;
      logic cordic_last;
      logic div_busy;
      logic mac_last;
   } status_type;

   function automatic logic signed [AngWidth-1:0] atan_q30(input logic [StepWidth-1:0] idx);
      logic signed [AngWidth-1:0] v;
      case (idx)
         5'd0:  v = 34'sd843314856;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043836;
         5'd3:  v = 34'sd133525158;
         5'd4:  v = 34'sd67021686;
         5'd5:  v = 34'sd33543515;
         5'd6:  v = 34'sd16775850;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194282;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048575;
         5'd11: v = 34'sd524287;
         5'd12: v = 34'sd262143;
         5'd13: v = 34'sd131071;
         5'd14: v = 34'sd65535;
         5'd15: v = 34'sd32767;
         5'd16: v = 34'sd16383;
         5'd17: v = 34'sd8191;
         5'd18: v = 34'sd4095;
         5'd19: v = 34'sd2047;
         5'd20: v = 34'sd1023;
         5'd21: v = 34'sd511;
         5'd22: v = 34'sd255;
         5'd23: v = 34'sd127;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [VelWidth-1:0] sat32(input logic signed [SatInWidth-1:0] v);
      logic signed [VelWidth-1:0] r;
      if (v > 48'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -48'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[VelWidth-1:0];
      end
      return r;
   endfunction

endpackage

// File: sv/pdbv_divider.sv
// Restoring signed-by-unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pdbv_divider #(
   parameter int DividendWidth = 43,
   parameter int DivisorWidth  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [DividendWidth-1:0] dividend,
   input  logic        [DivisorWidth-1:0]  divisor,
   output logic signed [DividendWidth-1:0] quotient,
   output logic                            busy
);

   localparam int CntWidth = $clog2(DividendWidth + 1);

   logic [DivisorWidth-1:0]  rem_ff, rem_in;
   logic [DividendWidth-1:0] quo_ff, quo_in;
   logic [DivisorWidth-1:0]  div_ff;
   logic                     neg_ff;
   logic [CntWidth-1:0]      cnt_ff, cnt_in;
   logic [DivisorWidth:0]    shifted;
   logic [DivisorWidth:0]    diff;
   logic                     ge;

   assign shifted = {rem_ff, quo_ff[DividendWidth-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign ge      = shifted >= {1'b0, div_ff};
   assign busy    = cnt_ff != '0;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend[DividendWidth-1] ? -dividend : dividend;
         cnt_in = CntWidth'(DividendWidth);
      end else if (busy) begin
         rem_in = ge ? diff[DivisorWidth-1:0] : shifted[DivisorWidth-1:0];
         quo_in = {quo_ff[DividendWidth-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         div_ff <= divisor;
         neg_ff <= dividend[DividendWidth-1];
      end
   end

   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

// File: sv/pdbv_controller.sv
// Sequencing state machine of the pose delta velocity block.
`timescale 1ns / 1ps
module pdbv_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pdbv_pkg::cmd_type    cmd,
   input  pdbv_pkg::status_type status
);

   localparam logic [3:0] StIdle    = 4'd0;
   localparam logic [3:0] StSquare  = 4'd1;
   localparam logic [3:0] StCross   = 4'd2;
   localparam logic [3:0] StSetup   = 4'd3;
   localparam logic [3:0] StVector  = 4'd4;
   localparam logic [3:0] StYaw     = 4'd5;
   localparam logic [3:0] StRotInit = 4'd6;
   localparam logic [3:0] StRotate  = 4'd7;
   localparam logic [3:0] StWait    = 4'd8;
   localparam logic [3:0] StMac     = 4'd9;
   localparam logic [3:0] StCommit  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !(rsp_valid_ff && rsp_stall);
   assign req_stall = state_ff != StIdle;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = StSquare;
            end
         end
         StSquare: begin
            cmd.prod_sq = 1'b1;
            state_in    = StCross;
         end
         StCross: begin
            cmd.prod_cross = 1'b1;
            state_in       = StSetup;
         end
         StSetup: begin
            cmd.setup_vec = 1'b1;
            state_in      = StVector;
         end
         StVector: begin
            cmd.cordic_step = 1'b1;
            cmd.cordic_vec  = 1'b1;
            if (status.cordic_last) state_in = StYaw;
         end
         StYaw: begin
            cmd.take_yaw = 1'b1;
            state_in     = status.hold ? StCommit : StRotInit;
         end
         StRotInit: begin
            cmd.setup_rot = 1'b1;
            state_in      = StRotate;
         end
         StRotate: begin
            cmd.cordic_step = 1'b1;
            if (status.cordic_last) state_in = StWait;
         end
         StWait: begin
            cmd.take_sc = 1'b1;
            if (!status.div_busy) state_in = StMac;
         end
         StMac: begin
            cmd.mac_step = 1'b1;
            if (status.mac_last) state_in = StCommit;
         end
         StCommit: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/pdbv_datapath.sv
// Datapath: quaternion products, shared CORDIC, dividers, rotation MAC and state.
`timescale 1ns / 1ps
module pdbv_datapath #(
   parameter int ROTATION_STEPS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pdbv_pkg::cmd_type            cmd,
   output pdbv_pkg::status_type         status,
   input  logic signed [31:0]           req_pos_x,
   input  logic signed [31:0]           req_pos_y,
   input  logic signed [15:0]           req_quat_x,
   input  logic signed [15:0]           req_quat_y,
   input  logic signed [15:0]           req_quat_z,
   input  logic signed [15:0]           req_quat_w,
   input  logic        [31:0]           req_stamp_ms,
   output logic signed [31:0]           rsp_body_vel_x,
   output logic signed [31:0]           rsp_body_vel_y,
   output logic signed [31:0]           rsp_yaw_rate,
   output logic                         rsp_held
);

   localparam int PW = pdbv_pkg::PosWidth;
   localparam int QW = pdbv_pkg::QuatWidth;
   localparam int TW = pdbv_pkg::StampWidth;
   localparam int VW = pdbv_pkg::VelWidth;
   localparam int YW = pdbv_pkg::YawWidth;
   localparam int MW = pdbv_pkg::ProdWidth;
   localparam int SW = pdbv_pkg::SumWidth;
   localparam int CW = pdbv_pkg::CordWidth;
   localparam int AW = pdbv_pkg::AngWidth;
   localparam int NW = pdbv_pkg::StepWidth;
   localparam int DW = pdbv_pkg::DivWidth;
   localparam int KW = pdbv_pkg::ScWidth;
   localparam int BW = pdbv_pkg::MacAWidth;
   localparam int RW = pdbv_pkg::MacPWidth;
   localparam int XW = pdbv_pkg::AccWidth;
   localparam int LW = pdbv_pkg::MacCntWidth;
   localparam int HW = DW - (BW - 1);

   logic signed [PW-1:0] in_px_ff, in_py_ff;
   logic signed [QW-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic        [TW-1:0] stamp_ff;
   logic signed [MW-1:0] sq_x_ff, sq_y_ff, sq_z_ff, sq_w_ff;
   logic signed [MW-1:0] p_xz_ff, p_wy_ff, p_xy_ff, p_wz_ff;
   logic                 gimbal_ff;
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic signed [AW-1:0] cz_ff;
   logic        [NW-1:0] step_ff;
   logic                 flip_ff;
   logic signed [YW-1:0] yaw_ff;
   logic signed [KW-1:0] c_ff, s_ff;
   logic signed [XW-1:0] accx_ff, accy_ff;
   logic        [LW-1:0] mac_ff;

   logic signed [PW-1:0] prev_px_ff, prev_py_ff;
   logic signed [YW-1:0] prev_yaw_ff;
   logic        [TW-1:0] prev_stamp_ff;
   logic signed [VW-1:0] held_vx_ff, held_vy_ff, held_rate_ff;
   logic                 primed_ff;
   logic                 rsp_held_ff;

   logic [TW-1:0] dt;
   logic          hold;
   assign dt   = stamp_ff - prev_stamp_ff;
   assign hold = !primed_ff || (dt == '0);

   // quaternion terms
   logic signed [SW-1:0] d_w, m20_w, vx0_w, vy0_w;
   logic                 gimbal_in;
   logic signed [CW-1:0] pre_x, pre_y;
   logic signed [AW-1:0] pre_z;

   assign d_w   = SW'(sq_w_ff) + SW'(sq_x_ff) + SW'(sq_y_ff) + SW'(sq_z_ff);
   assign m20_w = (SW'(p_xz_ff) - SW'(p_wy_ff)) <<< 1;
   assign vx0_w = d_w - ((SW'(sq_y_ff) + SW'(sq_z_ff)) <<< 1);
   assign vy0_w = (SW'(p_xy_ff) + SW'(p_wz_ff)) <<< 1;
   assign gimbal_in = (d_w == '0) || (m20_w >= d_w) || (-m20_w >= d_w);

   always_comb begin
      pre_x = CW'(vx0_w);
      pre_y = CW'(vy0_w);
      pre_z = '0;
      if (vx0_w < 0) begin
         if (vy0_w >= 0) begin
            pre_x = CW'(vy0_w);
            pre_y = -CW'(vx0_w);
            pre_z = pdbv_pkg::HalfPiQ30;
         end else begin
            pre_x = -CW'(vy0_w);
            pre_y = CW'(vx0_w);
            pre_z = -pdbv_pkg::HalfPiQ30;
         end
      end
   end

   // cordic iteration
   logic                 ccw;
   logic signed [CW-1:0] xs, ys, cx_in, cy_in;
   logic signed [AW-1:0] at, cz_in;

   assign ccw = cmd.cordic_vec ? !(cy_ff > 0) : !cz_ff[AW-1];
   assign xs  = cx_ff >>> step_ff;
   assign ys  = cy_ff >>> step_ff;
   assign at  = pdbv_pkg::atan_q30(step_ff);
   assign cx_in = ccw ? cx_ff - ys : cx_ff + ys;
   assign cy_in = ccw ? cy_ff + xs : cy_ff - xs;
   assign cz_in = ccw ? cz_ff - at : cz_ff + at;

   assign status.cordic_last = step_ff == NW'(ROTATION_STEPS - 1);

   // yaw from vectoring angle
   logic signed [AW-1:0] yaw_round;
   logic signed [YW:0]   yaw_wide;
   logic signed [YW-1:0] yaw_in;

   assign yaw_round = (cz_ff + AW'(65536)) >>> 17;
   assign yaw_wide  = yaw_round[YW:0];

   always_comb begin
      yaw_in = yaw_wide[YW-1:0];
      if (yaw_wide > pdbv_pkg::PiQ13) yaw_in = pdbv_pkg::PiQ13[YW-1:0];
      if (yaw_wide < -pdbv_pkg::PiQ13) yaw_in = -pdbv_pkg::PiQ13[YW-1:0];
      if (gimbal_ff) yaw_in = '0;
   end

   // rotation start angle
   logic signed [AW-1:0] rz0, rz_in;
   logic                 flip_in;

   assign rz0 = AW'(yaw_ff) <<< 17;

   always_comb begin
      rz_in   = rz0;
      flip_in = 1'b0;
      if (rz0 > pdbv_pkg::HalfPiQ30) begin
         rz_in   = rz0 - pdbv_pkg::PiQ30;
         flip_in = 1'b1;
      end else if (rz0 < -pdbv_pkg::HalfPiQ30) begin
         rz_in   = rz0 + pdbv_pkg::PiQ30;
         flip_in = 1'b1;
      end
   end

   // differences and dividends
   logic signed [YW:0]   dyaw_raw, dyaw_w;
   logic signed [YW-1:0] dyaw;
   logic signed [PW:0]   dpx, dpy;
   logic signed [DW-1:0] num_x, num_y, num_r;
   logic signed [DW-1:0] quo_x, quo_y, quo_r;
   logic                 busy_x, busy_y, busy_r;

   assign dyaw_raw = (YW + 1)'(yaw_ff) - (YW + 1)'(prev_yaw_ff);

   always_comb begin
      dyaw_w = dyaw_raw;
      if (dyaw_raw > pdbv_pkg::PiQ13) dyaw_w = dyaw_raw - pdbv_pkg::TwoPiQ13;
      else if (dyaw_raw < -pdbv_pkg::PiQ13) dyaw_w = dyaw_raw + pdbv_pkg::TwoPiQ13;
   end

   assign dyaw  = dyaw_w[YW-1:0];
   assign dpx   = (PW + 1)'(in_px_ff) - (PW + 1)'(prev_px_ff);
   assign dpy   = (PW + 1)'(in_py_ff) - (PW + 1)'(prev_py_ff);
   assign num_x = (DW'(dpx) <<< 10) - (DW'(dpx) <<< 4) - (DW'(dpx) <<< 3);
   assign num_y = (DW'(dpy) <<< 10) - (DW'(dpy) <<< 4) - (DW'(dpy) <<< 3);
   assign num_r = (DW'(dyaw) <<< 13) - (DW'(dyaw) <<< 7) - (DW'(dyaw) <<< 6);

   pdbv_divider #(.DividendWidth(DW), .DivisorWidth(TW)) u_div_x (
      .clock(clock), .reset(reset), .start(cmd.setup_rot),
      .dividend(num_x), .divisor(dt), .quotient(quo_x), .busy(busy_x)
   );

   pdbv_divider #(.DividendWidth(DW), .DivisorWidth(TW)) u_div_y (
      .clock(clock), .reset(reset), .start(cmd.setup_rot),
      .dividend(num_y), .divisor(dt), .quotient(quo_y), .busy(busy_y)
   );

   pdbv_divider #(.DividendWidth(DW), .DivisorWidth(TW)) u_div_r (
      .clock(clock), .reset(reset), .start(cmd.setup_rot),
      .dividend(num_r), .divisor(dt), .quotient(quo_r), .busy(busy_r)
   );

   assign status.div_busy = busy_x || busy_y || busy_r;
   assign status.hold     = hold;

   // sin and cos in Q.20
   logic signed [CW-1:0] cx_f, cy_f, c_sum, s_sum;
   assign cx_f  = flip_ff ? -cx_ff : cx_ff;
   assign cy_f  = flip_ff ? -cy_ff : cy_ff;
   assign c_sum = cx_f + CW'(512);
   assign s_sum = cy_f + CW'(512);

   // rotation multiply-accumulate, split operand
   logic signed [DW-1:0] mac_v;
   logic signed [KW-1:0] mac_b;
   logic signed [BW-1:0] mac_a;
   logic signed [RW-1:0] mac_p;
   logic signed [XW-1:0] mac_t;
   logic signed [HW-1:0] v_hi;

   assign mac_v = (mac_ff[2] ^ mac_ff[1]) ? quo_y : quo_x;
   assign mac_b = mac_ff[1] ? s_ff : c_ff;
   assign v_hi  = mac_v[DW-1:BW-1];
   assign mac_a = mac_ff[0] ? BW'(v_hi) : $signed({1'b0, mac_v[BW-2:0]});
   assign mac_p = mac_a * mac_b;
   assign mac_t = mac_ff[0] ? (XW'(mac_p) <<< (BW - 1)) : XW'(mac_p);

   assign status.mac_last = mac_ff == '1;

   // final rounding
   logic signed [XW-1:0] rx, ry;
   assign rx = (accx_ff + XW'(524288)) >>> 20;
   assign ry = (accy_ff + XW'(524288)) >>> 20;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_px_ff <= req_pos_x;
         in_py_ff <= req_pos_y;
         qx_ff    <= req_quat_x;
         qy_ff    <= req_quat_y;
         qz_ff    <= req_quat_z;
         qw_ff    <= req_quat_w;
         stamp_ff <= req_stamp_ms;
      end
      if (cmd.prod_sq) begin
         sq_x_ff <= qx_ff * qx_ff;
         sq_y_ff <= qy_ff * qy_ff;
         sq_z_ff <= qz_ff * qz_ff;
         sq_w_ff <= qw_ff * qw_ff;
      end
      if (cmd.prod_cross) begin
         p_xz_ff <= qx_ff * qz_ff;
         p_wy_ff <= qw_ff * qy_ff;
         p_xy_ff <= qx_ff * qy_ff;
         p_wz_ff <= qw_ff * qz_ff;
      end
      if (cmd.setup_vec) begin
         cx_ff     <= pre_x;
         cy_ff     <= pre_y;
         cz_ff     <= pre_z;
         gimbal_ff <= gimbal_in;
         step_ff   <= '0;
      end else if (cmd.setup_rot) begin
         cx_ff   <= pdbv_pkg::CordicGainQ30;
         cy_ff   <= '0;
         cz_ff   <= rz_in;
         flip_ff <= flip_in;
         step_ff <= '0;
         mac_ff  <= '0;
         accx_ff <= '0;
         accy_ff <= '0;
      end else if (cmd.cordic_step) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
         if (!status.cordic_last) step_ff <= step_ff + 1'b1;
      end
      if (cmd.take_yaw) yaw_ff <= yaw_in;
      if (cmd.take_sc) begin
         c_ff <= c_sum[KW+9:10];
         s_ff <= s_sum[KW+9:10];
      end
      if (cmd.mac_step) begin
         mac_ff <= mac_ff + 1'b1;
         if (!mac_ff[2]) accx_ff <= accx_ff + mac_t;
         else if (mac_ff[1]) accy_ff <= accy_ff - mac_t;
         else accy_ff <= accy_ff + mac_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_px_ff    <= '0;
         prev_py_ff    <= '0;
         prev_yaw_ff   <= '0;
         prev_stamp_ff <= '0;
         held_vx_ff    <= '0;
         held_vy_ff    <= '0;
         held_rate_ff  <= '0;
         primed_ff     <= 1'b0;
         rsp_held_ff   <= 1'b0;
      end else if (cmd.commit) begin
         rsp_held_ff <= hold;
         if (!hold) begin
            held_vx_ff   <= pdbv_pkg::sat32(pdbv_pkg::SatInWidth'(rx));
            held_vy_ff   <= pdbv_pkg::sat32(pdbv_pkg::SatInWidth'(ry));
            held_rate_ff <= pdbv_pkg::sat32(pdbv_pkg::SatInWidth'(quo_r));
         end
         if (!primed_ff || !hold) begin
            prev_px_ff    <= in_px_ff;
            prev_py_ff    <= in_py_ff;
            prev_yaw_ff   <= yaw_ff;
            prev_stamp_ff <= stamp_ff;
            primed_ff     <= 1'b1;
         end
      end
   end

   assign rsp_body_vel_x = held_vx_ff;
   assign rsp_body_vel_y = held_vy_ff;
   assign rsp_yaw_rate   = held_rate_ff;
   assign rsp_held       = rsp_held_ff;

endmodule

// File: sv/pose_delta_body_velocity_unit.sv
// Top level: body-frame velocity from successive timestamped pose samples.
// Flow: a held transaction runs the quaternion products and the vectoring CORDIC to commit;
// a moving one also runs the rotation CORDIC, waits on the bit-serial dividers and runs the MAC.
// Throughput: one transaction at a time; the next is accepted on the cycle after commit,
// while the previous response may still wait in the output register.
// Reset: synchronous; clears the stored pose, held velocities and primed flag to zero.
`timescale 1ns / 1ps
module pose_delta_body_velocity_unit #(
   parameter int ROTATION_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   input  logic        [31:0] req_stamp_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_body_vel_x,
   output logic signed [31:0] rsp_body_vel_y,
   output logic signed [31:0] rsp_yaw_rate,
   output logic               rsp_held
);

   pdbv_pkg::cmd_type    cmd;
   pdbv_pkg::status_type status;

   pdbv_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .cmd(cmd), .status(status)
   );

   pdbv_datapath #(.ROTATION_STEPS(ROTATION_STEPS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_quat_x(req_quat_x), .req_quat_y(req_quat_y),
      .req_quat_z(req_quat_z), .req_quat_w(req_quat_w),
      .req_stamp_ms(req_stamp_ms),
      .rsp_body_vel_x(rsp_body_vel_x), .rsp_body_vel_y(rsp_body_vel_y),
      .rsp_yaw_rate(rsp_yaw_rate), .rsp_held(rsp_held)
   );

endmodule

// File: sv/pdbv_checker.sv
// Port-level assertions for the pose delta velocity block, bound to the top level.
`timescale 1ns / 1ps
`include "pose_delta_body_velocity_unit_assert.svh"
module pdbv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_body_vel_x,
   input logic [31:0] rsp_body_vel_y,
   input logic [31:0] rsp_yaw_rate,
   input logic        rsp_held
);

   `PDBV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_body_vel_x, rsp_body_vel_y, rsp_yaw_rate, rsp_held}))
   `PDBV_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `PDBV_ASSERT_NOW(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))
   `PDBV_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && !req_stall, !$rose(rsp_valid))

endmodule

bind pose_delta_body_velocity_unit pdbv_checker u_pdbv_checker (.*);
